[hdl/occgrid_pkg.sv]
// ----------------------------------------------------------------------------
// occgrid_pkg
// shared constants for the occupancy grid block and its seed snap logic
// ----------------------------------------------------------------------------
package occgrid_pkg;

	localparam int DEF_MAX_GRID_W   = 256;
	localparam int DEF_MAX_GRID_H   = 256;
	localparam int DEF_SEARCH_RADIUS = 3;

	localparam int COORD_W  = 24;
	localparam int CS_W     = 23;
	localparam int DIM_W    = 9;
	localparam int DIMC_W   = 13;
	localparam int MARGIN_W = 8;
	localparam int CELL_W   = 8;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int DIV_NW   = 26;
	localparam int DIV_DW   = 24;
	localparam int RES_W    = 28;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd4;

	localparam logic [1:0] KIND_BOX    = 2'd0;
	localparam logic [1:0] KIND_SNAP   = 2'd1;
	localparam logic [1:0] KIND_SEED   = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [CS_W-1:0]  CS_RESET  = 23'd256;
	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

endpackage

[hdl/occgrid_div.sv]
// ----------------------------------------------------------------------------
// occgrid_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module occgrid_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic [occgrid_pkg::DIV_NW-1:0]  num,
	input  logic [occgrid_pkg::DIV_DW-1:0]  den,
	output logic                            done,
	output logic [occgrid_pkg::DIV_NW-1:0]  quo
);
	import occgrid_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				cnt_q <= CNT_W'(DIV_NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hdl/occgrid_mem.sv]
// ----------------------------------------------------------------------------
// occgrid_mem
// one-bit occupancy memory, single port, registered read
// ----------------------------------------------------------------------------
module occgrid_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);
	logic mem [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/occupancy_grid_block_and_seed_snap_unit.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_block_and_seed_snap_unit
// occupancy grid with box blocking and seed snapping to empty cells
// ----------------------------------------------------------------------------
// After reset the unit sweeps the grid memory to empty, one cell a cycle, over
// all MAX_GRID_W*MAX_GRID_H cells (65536 by default) with busy high. A command is
// taken when start is high and busy low; busy stays high until it is done.
// Each coordinate goes through one shared serial divider: four for a box,
// which then marks its cells, two for a seed, which then probes in-grid cells
// one at a time through the single memory port (up to 49 probes for radius 3,
// 84 counting rescanned cells).
// A result word shows on cell_x/cell_z for one cycle with result_valid high
// and cannot be held off; registers may be written whenever busy is low.
// ----------------------------------------------------------------------------
module occupancy_grid_block_and_seed_snap_unit #(
	parameter int MAX_GRID_W    = occgrid_pkg::DEF_MAX_GRID_W,
	parameter int MAX_GRID_H    = occgrid_pkg::DEF_MAX_GRID_H,
	parameter int SEARCH_RADIUS = occgrid_pkg::DEF_SEARCH_RADIUS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            kind,
	input  logic signed [occgrid_pkg::COORD_W-1:0] box_x_min,
	input  logic signed [occgrid_pkg::COORD_W-1:0] box_z_min,
	input  logic signed [occgrid_pkg::COORD_W-1:0] box_x_max,
	input  logic signed [occgrid_pkg::COORD_W-1:0] box_z_max,
	input  logic [occgrid_pkg::MARGIN_W-1:0]       margin,
	input  logic signed [occgrid_pkg::COORD_W-1:0] seed_x,
	input  logic signed [occgrid_pkg::COORD_W-1:0] seed_z,
	output logic                                  result_valid,
	output logic [occgrid_pkg::CELL_W-1:0]         cell_x,
	output logic [occgrid_pkg::CELL_W-1:0]         cell_z,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [occgrid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [occgrid_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import occgrid_pkg::*;

	localparam int DEPTH = MAX_GRID_W * MAX_GRID_H;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_GRID_W);
	localparam int ZW    = $clog2(MAX_GRID_H);
	localparam int RW    = $clog2(SEARCH_RADIUS + 1);
	localparam int OFW   = RW + 1;
	localparam int CW    = ((XW > ZW) ? XW : ZW) + OFW + 1;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_PREP  = 9'b000000100,
		S_LOAD  = 9'b000001000,
		S_DIV   = 9'b000010000,
		S_POST  = 9'b000100000,
		S_FILL  = 9'b001000000,
		S_ADDR  = 9'b010000000,
		S_CHECK = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [COORD_W-1:0] origin_x_q, origin_z_q;
	logic [CS_W-1:0]           cs_q;
	logic [DIM_W-1:0]          gw_q, gh_q;
	logic [CS_W-1:0]           cs_eff;
	logic [DIMC_W-1:0]         gw_eff, gh_eff;

	assign cfg_ready = !busy;
	assign cs_eff = (cs_q == '0) ? CS_W'(1) : cs_q;
	assign gw_eff = (gw_q == '0) ? DIMC_W'(1) :
		((DIMC_W'(gw_q) > DIMC_W'(MAX_GRID_W)) ? DIMC_W'(MAX_GRID_W) : DIMC_W'(gw_q));
	assign gh_eff = (gh_q == '0) ? DIMC_W'(1) :
		((DIMC_W'(gh_q) > DIMC_W'(MAX_GRID_H)) ? DIMC_W'(MAX_GRID_H) : DIMC_W'(gh_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
			cs_q       <= CS_RESET;
			gw_q       <= DIM_RESET;
			gh_q       <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIGIN_X:    origin_x_q <= $signed(cfg_data);
				CFG_ORIGIN_Z:    origin_z_q <= $signed(cfg_data);
				CFG_CELL_SIZE:   cs_q       <= cfg_data[CS_W-1:0];
				CFG_GRID_WIDTH:  gw_q       <= cfg_data[DIM_W-1:0];
				CFG_GRID_HEIGHT: gh_q       <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// captured command word
	logic [1:0]                kind_q;
	logic signed [COORD_W-1:0] c0_q, c1_q, c2_q, c3_q;
	logic [MARGIN_W-1:0]       margin_q;
	logic                      accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			margin_q <= margin;
			if (kind == KIND_BOX) begin
				c0_q <= box_x_min;
				c1_q <= box_z_min;
				c2_q <= box_x_max;
				c3_q <= box_z_max;
			end else begin
				c0_q <= seed_x;
				c1_q <= seed_z;
				c2_q <= seed_x;
				c3_q <= seed_z;
			end
		end
	end

	// coordinate to cell division
	logic [1:0]                op_q;
	logic signed [DIFF_W-1:0]  d_q;
	logic                      neg_q;
	logic signed [COORD_W-1:0] op_coord, op_org;
	logic [DIFF_W-1:0]         d_abs;
	logic                      is_round;
	logic                      div_load, div_done;
	logic [DIV_NW-1:0]         div_num, div_quo;
	logic [DIV_DW-1:0]         div_den;
	logic signed [RES_W-1:0]   res_q [4];
	logic signed [RES_W-1:0]   quo_signed;

	always_comb begin
		case (op_q)
			2'd0:    begin op_coord = c0_q; op_org = origin_x_q; end
			2'd1:    begin op_coord = c1_q; op_org = origin_z_q; end
			2'd2:    begin op_coord = c2_q; op_org = origin_x_q; end
			default: begin op_coord = c3_q; op_org = origin_z_q; end
		endcase
	end

	assign is_round = (kind_q != KIND_BOX);
	assign d_abs    = d_q[DIFF_W-1] ? DIFF_W'(-d_q) : DIFF_W'(d_q);

	always_comb begin
		if (is_round) begin
			// half away from zero: (2a + cs) / (2cs)
			div_num = DIV_NW'({d_abs, 1'b0}) + DIV_NW'(cs_eff);
			div_den = DIV_DW'({cs_eff, 1'b0});
		end else if (d_q[DIFF_W-1]) begin
			// floor of a negative value is minus the ceiling of its magnitude
			div_num = DIV_NW'(d_abs) + DIV_NW'(cs_eff) - DIV_NW'(1);
			div_den = DIV_DW'(cs_eff);
		end else begin
			div_num = DIV_NW'(d_abs);
			div_den = DIV_DW'(cs_eff);
		end
	end

	assign div_load   = (state_q == S_LOAD);
	assign quo_signed = neg_q ? -$signed(RES_W'(div_quo)) : $signed(RES_W'(div_quo));

	occgrid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// box bounds and fill walk
	logic [XW-1:0] x0_q, x1_q, fx_q;
	logic [ZW-1:0] z0_q, z1_q, fz_q;
	logic signed [RES_W-1:0] lo_x, hi_x, lo_z, hi_z, wmax, hmax;
	logic signed [RES_W-1:0] m_ext;

	assign m_ext = $signed(RES_W'(margin_q));
	assign wmax  = $signed(RES_W'(gw_eff)) - RES_W'(1);
	assign hmax  = $signed(RES_W'(gh_eff)) - RES_W'(1);

	always_comb begin
		lo_x = res_q[0] - m_ext;
		lo_z = res_q[1] - m_ext;
		hi_x = res_q[2] + m_ext;
		hi_z = res_q[3] + m_ext;
		if (lo_x < 0) lo_x = '0;
		if (lo_x > wmax) lo_x = wmax;
		if (lo_z < 0) lo_z = '0;
		if (lo_z > hmax) lo_z = hmax;
		if (hi_x < 0) hi_x = '0;
		if (hi_x > wmax) hi_x = wmax;
		if (hi_z < 0) hi_z = '0;
		if (hi_z > hmax) hi_z = hmax;
	end

	// seed search
	logic signed [CW-1:0]  cx_q, cz_q, nx_q, nz_q, nx, nz;
	logic [RW-1:0]         r_q, rlim_q;
	logic signed [OFW-1:0] ox_q, oy_q, ox_nx, oy_nx, r_s;
	logic [RW-1:0]         r_nx;
	logic                  scan_end, nb_in, seed_in;

	assign r_s = $signed({1'b0, r_q});
	assign nx  = cx_q + CW'(ox_q);
	assign nz  = cz_q + CW'(oy_q);
	assign nb_in = (nx >= 0) && (nz >= 0) &&
		(nx < $signed(CW'(gw_eff))) && (nz < $signed(CW'(gh_eff)));
	assign seed_in = (res_q[0] >= 0) && (res_q[1] >= 0) &&
		(res_q[0] < $signed(RES_W'(gw_eff))) && (res_q[1] < $signed(RES_W'(gh_eff)));
	assign scan_end = (ox_q == r_s) && (oy_q == r_s) && (r_q == rlim_q);

	// squares are scanned whole: inner cells were already found blocked
	always_comb begin
		ox_nx = ox_q;
		oy_nx = oy_q;
		r_nx  = r_q;
		if (ox_q != r_s) begin
			ox_nx = ox_q + OFW'(1);
		end else if (oy_q != r_s) begin
			ox_nx = -r_s;
			oy_nx = oy_q + OFW'(1);
		end else begin
			r_nx  = r_q + RW'(1);
			ox_nx = -$signed({1'b0, r_nx});
			oy_nx = -$signed({1'b0, r_nx});
		end
	end

	// memory port
	logic [AW-1:0] clr_q, mem_addr;
	logic          mem_we, mem_wdata, mem_rdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = 1'b1;
				mem_addr  = AW'(fz_q) * AW'(MAX_GRID_W) + AW'(fx_q);
			end
			default: begin
				mem_addr = AW'(nz[ZW-1:0]) * AW'(MAX_GRID_W) + AW'(nx[XW-1:0]);
			end
		endcase
	end

	occgrid_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// sequencer
	logic                result_valid_q;
	logic [CELL_W-1:0]   cell_x_q, cell_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			op_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					op_q <= '0;
					if (accept) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= (kind_q == KIND_NONE) ? S_IDLE : S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						op_q <= op_q + 2'd1;
						if ((is_round && op_q == 2'd1) || op_q == 2'd3) begin
							state_q <= S_POST;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_POST: begin
					if (!is_round) begin
						state_q <= (lo_x <= hi_x && lo_z <= hi_z) ? S_FILL : S_IDLE;
					end else begin
						state_q <= seed_in ? S_ADDR : S_IDLE;
					end
				end
				S_FILL: begin
					if (fx_q == x1_q && fz_q == z1_q) begin
						state_q <= S_IDLE;
					end
				end
				S_ADDR: begin
					if (nb_in) begin
						state_q <= S_CHECK;
					end else if (scan_end) begin
						state_q <= S_IDLE;
					end
				end
				S_CHECK: begin
					if (!mem_rdata) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else if (scan_end) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ADDR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_PREP: begin
				d_q <= DIFF_W'(op_coord) - DIFF_W'(op_org);
			end
			S_LOAD: begin
				neg_q <= d_q[DIFF_W-1];
			end
			S_DIV: begin
				if (div_done) begin
					res_q[op_q] <= quo_signed;
				end
			end
			S_POST: begin
				x0_q <= lo_x[XW-1:0];
				z0_q <= lo_z[ZW-1:0];
				x1_q <= hi_x[XW-1:0];
				z1_q <= hi_z[ZW-1:0];
				fx_q <= lo_x[XW-1:0];
				fz_q <= lo_z[ZW-1:0];
				cx_q <= CW'(res_q[0]);
				cz_q <= CW'(res_q[1]);
				r_q  <= '0;
				ox_q <= '0;
				oy_q <= '0;
				rlim_q <= (kind_q == KIND_SNAP) ? RW'(SEARCH_RADIUS) : '0;
			end
			S_FILL: begin
				if (fx_q == x1_q) begin
					fx_q <= x0_q;
					fz_q <= fz_q + ZW'(1);
				end else begin
					fx_q <= fx_q + XW'(1);
				end
			end
			S_ADDR: begin
				nx_q <= nx;
				nz_q <= nz;
				if (!nb_in) begin
					ox_q <= ox_nx;
					oy_q <= oy_nx;
					r_q  <= r_nx;
				end
			end
			S_CHECK: begin
				ox_q <= ox_nx;
				oy_q <= oy_nx;
				r_q  <= r_nx;
				cell_x_q <= CELL_W'(nx_q[XW-1:0]);
				cell_z_q <= CELL_W'(nz_q[ZW-1:0]);
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign cell_x       = cell_x_q;
	assign cell_z       = cell_z_q;

	// a result only follows a memory probe that read an empty cell
	a_result_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == S_CHECK) && !$past(mem_rdata))
		else $error("result without an empty probe");

	// fill walk never leaves the clamped rectangle
	a_fill_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> fx_q >= x0_q && fx_q <= x1_q && fz_q >= z0_q && fz_q <= z1_q)
		else $error("fill outside box");

	// an accepted command holds the unit busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("command accepted but unit not busy");

	// probes only address cells inside the grid in use
	a_probe_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> nx_q >= 0 && nz_q >= 0 &&
			nx_q < $signed(CW'(gw_eff)) && nz_q < $signed(CW'(gh_eff)))
		else $error("probe outside grid");

endmodule
